### hw/rtl/spm_pkg.sv
// spm_pkg: shared types and constants of the schedule period matcher
// no dependencies; imported by the controller, the datapath and the top level
package spm_pkg;

  // table geometry
  localparam int MAX_PERIODS = 8;
  localparam int IDX_W = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int CNT_W = $clog2(MAX_PERIODS + 1);

  // command codes of an input item
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // fixed values of the forced period type
  localparam logic [7:0]         FORCED_KIND = 8'd2;
  localparam logic signed [15:0] FORCED_LOW  = 16'sd32000;
  localparam logic signed [15:0] FORCED_HIGH = 16'sd100;

  // gate limits above this value switch the gate off
  localparam logic signed [7:0]  GATE_OFF_ABOVE = 8'sd100;
  // temperatures at or below this value mean no reading
  localparam logic signed [11:0] NO_TEMP_TENTHS = -12'sd1000;

  // one stored period
  typedef struct packed {
    logic [11:0]        window_start;
    logic [11:0]        window_end;
    logic [7:0]         period_kind;
    logic signed [7:0]  gate_low;
    logic signed [7:0]  gate_high;
    logic signed [15:0] power_low;
    logic signed [15:0] power_high;
  } spm_entry_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } spm_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;       // clear the result accumulators
    logic wr_en;       // store the incoming period
    logic load_query;  // capture query time, temperature and slot count
    logic rd_issue;    // read the slot at the scan index
    logic out_load;    // move the accumulators into the output register
  } spm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;      // no slot takes part in matching
    logic last_slot;   // scan index is at the last active slot
  } spm_stat_t;

endpackage

### hw/rtl/spm_in_if.sv
// spm_in_if: input item channel of the schedule period matcher
// depends on nothing; valid/ready handshake with the item payload
interface spm_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [2:0]         slot;
  logic [11:0]        window_start;
  logic [11:0]        window_end;
  logic [7:0]         period_kind;
  logic signed [7:0]  gate_low;
  logic signed [7:0]  gate_high;
  logic signed [15:0] power_low;
  logic signed [15:0] power_high;
  logic [11:0]        query_time;
  logic signed [11:0] temperature_tenths;

  modport source (
    output valid, cmd, slot, window_start, window_end, period_kind, gate_low,
           gate_high, power_low, power_high, query_time, temperature_tenths,
    input  ready
  );

  modport sink (
    input  valid, cmd, slot, window_start, window_end, period_kind, gate_low,
           gate_high, power_low, power_high, query_time, temperature_tenths,
    output ready
  );
endinterface

### hw/rtl/spm_out_if.sv
// spm_out_if: result channel of the schedule period matcher
// depends on nothing; valid/ready handshake with the result payload
interface spm_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         matched_kind;
  logic [7:0]         gated_kind;
  logic signed [15:0] threshold_low;
  logic signed [15:0] threshold_high;

  modport source (
    output valid, matched_kind, gated_kind, threshold_low, threshold_high,
    input  ready
  );

  modport sink (
    input  valid, matched_kind, gated_kind, threshold_low, threshold_high,
    output ready
  );
endinterface

### hw/rtl/spm_ctrl.sv
// spm_ctrl: sequencing state machine of the schedule period matcher
// depends on spm_pkg; drives spm_dpath through spm_cmd_t, reads spm_stat_t
module spm_ctrl import spm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_cmd_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  spm_stat_t stat_i,
  output spm_cmd_t  cmd_o
);

  spm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.clear = 1'b1;
          if (in_cmd_i == CMD_WRITE) begin
            cmd_o.wr_en = 1'b1;
            state_d     = ST_DONE;
          end else begin
            cmd_o.load_query = 1'b1;
            state_d          = stat_i.n_zero ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_issue = 1'b1;
        if (stat_i.last_slot) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last slot read is evaluated in this cycle
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // scan is never entered with no active slot
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_cmd_i == CMD_QUERY && stat_i.n_zero)
      |=> state_q == ST_DONE)
    else $error("query with no active slot entered the scan");

  // drain only follows the scan
  a_drain_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> $past(state_q) == ST_SCAN)
    else $error("drain state entered outside a scan");

  // a finished result with a free output register goes out at once
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("result held back while output register was free");

endmodule

### hw/rtl/spm_dpath.sv
// spm_dpath: period table, slot scan and result accumulators
// depends on spm_pkg; controlled by spm_ctrl via spm_cmd_t
module spm_dpath import spm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  spm_cmd_t           cmd_i,
  output spm_stat_t          stat_o,
  input  logic [2:0]         slot_i,
  input  spm_entry_t         entry_i,
  input  logic [11:0]        query_time_i,
  input  logic signed [11:0] temperature_tenths_i,
  output logic [7:0]         matched_kind_o,
  output logic [7:0]         gated_kind_o,
  output logic signed [15:0] threshold_low_o,
  output logic signed [15:0] threshold_high_o
);

  logic [3:0]         active_q;
  logic [CNT_W-1:0]   n_act;
  logic [CNT_W-1:0]   n_q;
  logic [IDX_W-1:0]   idx_q;
  logic               eval_q;
  logic [11:0]        time_q;
  logic signed [11:0] temp_q;
  spm_entry_t         mem_q [MAX_PERIODS];
  spm_entry_t         rd_q;
  logic [7:0]         mk_q, gk_q;
  logic signed [15:0] tl_q, th_q;
  logic [7:0]         mk_out_q, gk_out_q;
  logic signed [15:0] tl_out_q, th_out_q;
  logic               hit, gating, fail_lo, fail_hi, temp_ok;
  logic signed [12:0] temp13, lo_tenths, hi_tenths;

  // active slot count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // count saturates at the table depth
  assign n_act = (int'(active_q) > MAX_PERIODS) ? CNT_W'(MAX_PERIODS) : CNT_W'(active_q);

  // scan control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      eval_q <= 1'b0;
      n_q    <= '0;
    end else begin
      eval_q <= cmd_i.rd_issue;
      if (cmd_i.load_query) begin
        idx_q <= '0;
        n_q   <= n_act;
      end else if (cmd_i.rd_issue) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign stat_o.n_zero    = (n_act == '0);
  assign stat_o.last_slot = (CNT_W'(CNT_W'(idx_q) + 1'b1) == n_q);

  // query operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      time_q <= query_time_i;
      temp_q <= temperature_tenths_i;
    end
  end

  // period table, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && int'(slot_i) < MAX_PERIODS) begin
      mem_q[IDX_W'(slot_i)] <= entry_i;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // time window and temperature gates of the slot just read
  assign hit       = (time_q >= rd_q.window_start) && (time_q <= rd_q.window_end);
  assign gating    = temp_q > NO_TEMP_TENTHS;
  assign temp13    = 13'(temp_q);
  assign lo_tenths = 13'(rd_q.gate_low) * 13'sd10;
  assign hi_tenths = 13'(rd_q.gate_high) * 13'sd10;
  assign fail_lo   = (rd_q.gate_low <= GATE_OFF_ABOVE) && (temp13 > lo_tenths);
  assign fail_hi   = (rd_q.gate_high <= GATE_OFF_ABOVE) && (temp13 < hi_tenths);
  assign temp_ok   = !gating || !(fail_lo || fail_hi);

  // accumulators, last match wins
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mk_q <= '0;
      gk_q <= '0;
      tl_q <= '0;
      th_q <= '0;
    end else if (eval_q && hit) begin
      mk_q <= rd_q.period_kind;
      if (temp_ok) begin
        gk_q <= rd_q.period_kind;
      end
      if (rd_q.period_kind == FORCED_KIND) begin
        tl_q <= FORCED_LOW;
        th_q <= FORCED_HIGH;
      end else begin
        tl_q <= rd_q.power_low;
        th_q <= rd_q.power_high;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mk_out_q <= mk_q;
      gk_out_q <= gk_q;
      tl_out_q <= tl_q;
      th_out_q <= th_q;
    end
  end

  assign matched_kind_o   = mk_out_q;
  assign gated_kind_o     = gk_out_q;
  assign threshold_low_o  = tl_out_q;
  assign threshold_high_o = th_out_q;

endmodule

### hw/rtl/schedule_period_matcher.sv
// schedule_period_matcher: top level, joins spm_ctrl and spm_dpath to the channels
// depends on spm_pkg, spm_in_if, spm_out_if, spm_ctrl and spm_dpath
//
//  port         dir  handshake        carries
//  req_i        in   valid/ready      write or query item
//  rsp_o        out  valid/ready      matched kind, gated kind, power thresholds
//  cfg_we_i     in   write enable     active_periods (cfg_wdata_i, 4 bit)
//
// a write item, or a query with no active slot, goes from idle straight to the done
// state, which loads its result into the output register; a query over n active
// slots (capped at the table depth) walks them one slot per cycle through the
// single read port of the period table, then passes a drain state for the last
// read before done. a new item transfers only once the block is back in idle.
// the next item is taken while a result waits in the output register; it then
// holds in its last step until that register drains.
// reset clears control state and the slot count; table contents stay undefined
// until written.
module schedule_period_matcher import spm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,
  spm_in_if.sink       req_i,
  spm_out_if.source    rsp_o
);

  spm_cmd_t   cmd;
  spm_stat_t  stat;
  spm_entry_t entry;

  // pack the incoming period
  assign entry = '{
    window_start: req_i.window_start,
    window_end:   req_i.window_end,
    period_kind:  req_i.period_kind,
    gate_low:     req_i.gate_low,
    gate_high:    req_i.gate_high,
    power_low:    req_i.power_low,
    power_high:   req_i.power_high
  };

  // sequencing
  spm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_cmd_i    (req_i.cmd),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // table and matching
  spm_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .slot_i               (req_i.slot),
    .entry_i              (entry),
    .query_time_i         (req_i.query_time),
    .temperature_tenths_i (req_i.temperature_tenths),
    .matched_kind_o       (rsp_o.matched_kind),
    .gated_kind_o         (rsp_o.gated_kind),
    .threshold_low_o      (rsp_o.threshold_low),
    .threshold_high_o     (rsp_o.threshold_high)
  );

endmodule
